// ===== sv/ffb_pkg.sv =====
// ----------------------------------------------------------------------------
// First-free bitmap allocator: shared package
// Status and operation codes, field widths and the result of the zero scanner.
// ----------------------------------------------------------------------------
package ffb_pkg;

  localparam int WORD_BITS     = 64;
  localparam int INDEX_LIMIT   = 32768;
  localparam int IDX_W         = 15;
  localparam int LIM_W         = 16;
  localparam int NWORDS_W      = 10;
  localparam int CFG_W         = 4;

  localparam logic [CFG_W-1:0] BLOCKS_RESET = 4'd8;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_ERR  = 2'd2
  } ffb_status_t;

  typedef struct packed {
    logic       done;
    logic       found;
    logic [5:0] pos;
  } ffb_scan_res_t;

endpackage

// ===== sv/ffb_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port with registered read data, read-first.
// ----------------------------------------------------------------------------
module ffb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 512,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/ffb_scan.sv =====
// ----------------------------------------------------------------------------
// Lowest-zero scanner
// Shifts a 64-bit operand down one byte per cycle and reports the position of
// its lowest clear bit, or that every bit is set.
// ----------------------------------------------------------------------------
module ffb_scan
  import ffb_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [63:0]   operand,
  output ffb_scan_res_t res
);

  logic [63:0] op_r, op_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [7:0]  inv_byte;
  logic [2:0]  sub;
  logic        hit;

  always_comb begin
    inv_byte = ~op_r[7:0];
    hit      = 1'b0;
    sub      = '0;
    // Walk downwards so that the lowest clear bit wins.
    for (int i = 7; i >= 0; i--) begin
      if (inv_byte[i]) begin
        hit = 1'b1;
        sub = 3'(i);
      end
    end
    res.done  = busy_r && (hit || (cnt_r == 3'd7));
    res.found = busy_r && hit;
    res.pos   = {cnt_r, sub};
  end

  always_comb begin
    op_nxt   = op_r >> 8;
    cnt_nxt  = cnt_r + 3'd1;
    busy_nxt = busy_r && !res.done;
    if (start) begin
      op_nxt   = operand;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt;
  end

endmodule

// ===== sv/first_free_bitmap_allocator_top.sv =====
// ----------------------------------------------------------------------------
// First-free bitmap allocator
// Allocates the lowest clear bit of a bitmap store and frees named bits.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake          | Content
//  in_     | input     | in_tvalid/tready   | tdata: bit_index, tuser: func
//  out_    | output    | out_tvalid/tready  | tdata: alloc_index, tuser: status
//  cfg_    | input     | cfg_valid/ready    | cfg_data: blocks_in_use
//
//  A free reads its word and checks the bit; one out of range goes straight
//  to the result. An allocate scans summary entries in turn until one shows
//  a word that is not full, then scans that word, both with the byte-serial
//  zero scanner. An allocate with no blocks managed goes straight to the result.
//  No clearing pass: a fill count and per-entry valid bits stand for reset.
//  One transaction is in flight at a time; a finished result waits in the
//  output register while the next transaction is taken.
// ----------------------------------------------------------------------------
module first_free_bitmap_allocator_top
  import ffb_pkg::*;
#(
  parameter int BITS_PER_BLOCK = 4096,
  parameter int MAX_BLOCKS     = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [14:0] bit_index, [15] zero
  input  logic [0:0]  in_tuser,   // [0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [14:0] alloc_index, [15] zero
  output logic [1:0]  out_tuser,  // [1:0] status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data
);

  localparam int RAW_BITS = MAX_BLOCKS * BITS_PER_BLOCK;
  localparam int CAP_BITS = (RAW_BITS > INDEX_LIMIT) ? INDEX_LIMIT : RAW_BITS;
  localparam int DEPTH    = CAP_BITS / WORD_BITS;
  localparam int GROUPS   = (DEPTH + WORD_BITS - 1) / WORD_BITS;
  localparam int WAW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int GAW      = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int CW       = WAW + 1;

  typedef enum logic [9:0] {
    S_IDLE    = 10'b00_0000_0001,
    S_AS_RD   = 10'b00_0000_0010,
    S_AS_LD   = 10'b00_0000_0100,
    S_AS_SCAN = 10'b00_0000_1000,
    S_AW_RD   = 10'b00_0001_0000,
    S_AW_LD   = 10'b00_0010_0000,
    S_AW_SCAN = 10'b00_0100_0000,
    S_F_RD    = 10'b00_1000_0000,
    S_F_CHK   = 10'b01_0000_0000,
    S_RESP    = 10'b10_0000_0000
  } fsm_state_t;

  // Number of addressable managed bits for a given register value.
  function automatic logic [LIM_W-1:0] calc_limit(input logic [CFG_W-1:0] blk);
    logic [6:0]  b;
    logic [31:0] prod;
    b = {3'b000, blk};
    if (b > 7'(MAX_BLOCKS)) begin
      b = 7'(MAX_BLOCKS);
    end
    prod = 32'(b) * 32'(BITS_PER_BLOCK);
    if (prod > 32'(INDEX_LIMIT)) begin
      prod = 32'(INDEX_LIMIT);
    end
    return prod[LIM_W-1:0];
  endfunction

  fsm_state_t         state_r, state_nxt;
  logic [LIM_W-1:0]   lim_r, lim_nxt;
  logic [GAW-1:0]     g_r, g_nxt;
  logic [WAW-1:0]     w_r, w_nxt;
  logic [5:0]         k_r, k_nxt;
  logic [5:0]         p_r, p_nxt;
  logic [63:0]        sum_r, sum_nxt;
  logic [63:0]        word_r, word_nxt;
  logic [CW-1:0]      fill_r, fill_nxt;
  logic [GROUPS-1:0]  svld_r, svld_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  ffb_status_t        st_r, st_nxt;
  logic               out_vld_r, out_vld_nxt;
  logic [IDX_W-1:0]   out_idx_r, out_idx_nxt;
  ffb_status_t        out_st_r, out_st_nxt;

  logic [NWORDS_W-1:0] nwords;
  logic [NWORDS_W-1:0] nwords_m1;
  logic [NWORDS_W-1:0] last_sh;
  logic [GAW-1:0]      last_g;
  logic [63:0]         tail_mask;
  logic [8:0]          fw;
  logic [8:0]          gw;
  logic [GAW+5:0]      aw;
  logic [63:0]         new_word;
  logic [63:0]         word_rd;
  logic [63:0]         sum_rd;
  logic [63:0]         wram_q;
  logic [63:0]         sram_q;
  logic                wram_we;
  logic [63:0]         wram_wd;
  logic                sram_we;
  logic [63:0]         sram_wd;
  logic                scan_start;
  logic [63:0]         scan_op;
  ffb_scan_res_t       scan_res;

  // Word store and its fullness summary, one summary bit per word.
  ffb_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_word_ram (
    .clk   (clk),
    .we    (wram_we),
    .waddr (w_r),
    .wdata (wram_wd),
    .raddr (w_r),
    .rdata (wram_q)
  );

  ffb_ram #(.WIDTH(64), .DEPTH(GROUPS)) u_sum_ram (
    .clk   (clk),
    .we    (sram_we),
    .waddr (g_r),
    .wdata (sram_wd),
    .raddr (g_r),
    .rdata (sram_q)
  );

  ffb_scan u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (scan_start),
    .operand (scan_op),
    .res     (scan_res)
  );

  // Words are only ever written as a growing prefix, so anything at or above
  // the fill count has never been written and reads as free.
  assign word_rd = ({1'b0, w_r} < fill_r) ? wram_q : '0;
  assign sum_rd  = svld_r[g_r] ? sram_q : '0;

  assign nwords    = lim_r[LIM_W-1:6];
  assign nwords_m1 = nwords - NWORDS_W'(1);
  assign last_sh   = nwords_m1 >> 6;
  assign last_g    = last_sh[GAW-1:0];

  // Words past the managed range look full to the summary scan.
  always_comb begin
    tail_mask = '0;
    if ((g_r == last_g) && (nwords[5:0] != 6'd0)) begin
      tail_mask = ~((64'd1 << nwords[5:0]) - 64'd1);
    end
  end

  assign fw       = in_tdata[14:6];
  assign gw       = fw >> 6;
  assign aw       = {g_r, scan_res.pos};
  assign new_word = word_r | (64'd1 << scan_res.pos);

  always_comb begin
    state_nxt   = state_r;
    lim_nxt     = lim_r;
    g_nxt       = g_r;
    w_nxt       = w_r;
    k_nxt       = k_r;
    p_nxt       = p_r;
    sum_nxt     = sum_r;
    word_nxt    = word_r;
    fill_nxt    = fill_r;
    svld_nxt    = svld_r;
    idx_nxt     = idx_r;
    st_nxt      = st_r;
    out_vld_nxt = out_vld_r;
    out_idx_nxt = out_idx_r;
    out_st_nxt  = out_st_r;
    scan_start  = 1'b0;
    scan_op     = sum_rd | tail_mask;
    wram_we     = 1'b0;
    wram_wd     = word_r;
    sram_we     = 1'b0;
    sram_wd     = sum_r;

    if (cfg_valid) begin
      lim_nxt = calc_limit(cfg_data);
    end

    if (out_vld_r && out_tready) begin
      out_vld_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          idx_nxt = '0;
          if (in_tuser[0] == FUNC_ALLOC) begin
            g_nxt = '0;
            if (nwords == '0) begin
              st_nxt    = ST_FULL;
              state_nxt = S_RESP;
            end else begin
              state_nxt = S_AS_RD;
            end
          end else if (({1'b0, in_tdata[14:0]} < lim_r) &&
                       ({1'b0, fw} < 10'(DEPTH))) begin
            w_nxt     = fw[WAW-1:0];
            g_nxt     = gw[GAW-1:0];
            k_nxt     = fw[5:0];
            p_nxt     = in_tdata[5:0];
            state_nxt = S_F_RD;
          end else begin
            st_nxt    = ST_ERR;
            state_nxt = S_RESP;
          end
        end
      end
      S_AS_RD: begin
        state_nxt = S_AS_LD;
      end
      S_AS_LD: begin
        sum_nxt    = sum_rd;
        scan_start = 1'b1;
        state_nxt  = S_AS_SCAN;
      end
      S_AS_SCAN: begin
        if (scan_res.done) begin
          if (scan_res.found) begin
            k_nxt     = scan_res.pos;
            w_nxt     = aw[WAW-1:0];
            state_nxt = S_AW_RD;
          end else if (g_r == last_g) begin
            st_nxt    = ST_FULL;
            state_nxt = S_RESP;
          end else begin
            g_nxt     = g_r + GAW'(1);
            state_nxt = S_AS_RD;
          end
        end
      end
      S_AW_RD: begin
        state_nxt = S_AW_LD;
      end
      S_AW_LD: begin
        word_nxt   = word_rd;
        scan_op    = word_rd;
        scan_start = 1'b1;
        state_nxt  = S_AW_SCAN;
      end
      S_AW_SCAN: begin
        if (scan_res.done) begin
          if (scan_res.found) begin
            wram_we = 1'b1;
            wram_wd = new_word;
            if ({1'b0, w_r} == fill_r) begin
              fill_nxt = fill_r + CW'(1);
            end
            // A word that has just filled up is marked in the summary.
            if (&new_word) begin
              sram_we       = 1'b1;
              sram_wd       = sum_r | (64'd1 << k_r);
              svld_nxt[g_r] = 1'b1;
            end
            idx_nxt = IDX_W'({w_r, scan_res.pos});
            st_nxt  = ST_OK;
          end else begin
            st_nxt = ST_FULL;
          end
          state_nxt = S_RESP;
        end
      end
      S_F_RD: begin
        state_nxt = S_F_CHK;
      end
      S_F_CHK: begin
        if (word_rd[p_r]) begin
          wram_we       = 1'b1;
          wram_wd       = word_rd & ~(64'd1 << p_r);
          sram_we       = 1'b1;
          sram_wd       = sum_rd & ~(64'd1 << k_r);
          svld_nxt[g_r] = 1'b1;
          st_nxt        = ST_OK;
        end else begin
          st_nxt = ST_ERR;
        end
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!out_vld_r || out_tready) begin
          out_vld_nxt = 1'b1;
          out_idx_nxt = idx_r;
          out_st_nxt  = st_r;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      lim_r     <= calc_limit(BLOCKS_RESET);
      fill_r    <= '0;
      svld_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      lim_r     <= lim_nxt;
      fill_r    <= fill_nxt;
      svld_r    <= svld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    g_r       <= g_nxt;
    w_r       <= w_nxt;
    k_r       <= k_nxt;
    p_r       <= p_nxt;
    sum_r     <= sum_nxt;
    word_r    <= word_nxt;
    idx_r     <= idx_nxt;
    st_r      <= st_nxt;
    out_idx_r <= out_idx_nxt;
    out_st_r  <= out_st_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = {1'b0, out_idx_r};
  assign out_tuser  = out_st_r;

endmodule

// ===== sv/ffb_chk.sv =====
// ----------------------------------------------------------------------------
// First-free bitmap allocator: port checker
// Watches the top level's ports and is bound to every instance of it.
// ----------------------------------------------------------------------------
module ffb_chk
  import ffb_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // A stalled result must hold until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // Only one transaction is worked on at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken again before the result was produced");

  // A result never rises in the cycle after acceptance.
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !$rose(out_tvalid))
    else $error("result appeared in the cycle after acceptance");

  // Failed transactions carry a zero index.
  a_fail_zero_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != ST_OK) |-> (out_tdata == 16'd0))
    else $error("non-zero index on a failed transaction");

endmodule

bind first_free_bitmap_allocator_top ffb_chk u_ffb_chk (.*);

// ===== tb/sv/ffb_allocation_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// First-free bitmap allocator: result checker
// Watches the request, result and configuration channels. Keeps a shadow
// bitmap and block count, works out the grant for every accepted request and
// compares each result transaction with the oldest grant still waiting.
// ----------------------------------------------------------------------------
module ffb_allocation_checker
  import ffb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,   // [14:0] bit_index, [15] zero
  input  logic [0:0]  in_tuser,   // [0] func
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,  // [14:0] alloc_index, [15] zero
  input  logic [1:0]  out_tuser,  // [1:0] status
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [3:0]  cfg_data,
  output int          mismatch_count,
  output int          grants_pending
);

  localparam int MAP_WORDS     = 512;
  localparam int BITS_IN_BLOCK = 4096;
  localparam int BLOCK_MAX     = 8;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    ffb_status_t      status;
  } grant_t;

  logic [WORD_BITS-1:0] shadow_map [MAP_WORDS];
  logic [CFG_W-1:0]     shadow_blocks;
  grant_t               grant_q [$];
  int                   fail_total;

  // Applies one request to the shadow bitmap and returns the grant it earns.
  function automatic grant_t predict_grant(input logic func, input logic [IDX_W-1:0] idx);
    grant_t g;
    int     blk;
    int     limit;
    int     w;
    int     p;
    logic   found;
    g.idx    = '0;
    g.status = ST_OK;
    blk      = (int'(shadow_blocks) > BLOCK_MAX) ? BLOCK_MAX : int'(shadow_blocks);
    limit    = blk * BITS_IN_BLOCK;
    if (limit > INDEX_LIMIT) limit = INDEX_LIMIT;
    if (func == FUNC_ALLOC) begin
      found = 1'b0;
      for (w = 0; w < limit / WORD_BITS && !found; w++) begin
        if (shadow_map[w] != {WORD_BITS{1'b1}}) begin
          p = 0;
          while (shadow_map[w][p]) p++;
          shadow_map[w][p] = 1'b1;
          g.idx = IDX_W'(w * WORD_BITS + p);
          found = 1'b1;
        end
      end
      if (!found) g.status = ST_FULL;
    end else if (int'(idx) >= limit || !shadow_map[idx[IDX_W-1:6]][idx[5:0]]) begin
      // Out of range and double free both leave the store untouched.
      g.status = ST_ERR;
    end else begin
      shadow_map[idx[IDX_W-1:6]][idx[5:0]] = 1'b0;
    end
    return g;
  endfunction

  always @(posedge clk) begin
    grant_t g;
    if (!rst_n) begin
      for (int i = 0; i < MAP_WORDS; i++) shadow_map[i] = '0;
      shadow_blocks = BLOCKS_RESET;
      grant_q.delete();
      fail_total = 0;
    end else begin
      if (cfg_valid && cfg_ready) shadow_blocks = cfg_data;
      if (in_tvalid && in_tready)
        grant_q.push_back(predict_grant(in_tuser[0], in_tdata[IDX_W-1:0]));
      if (out_tvalid && out_tready) begin
        if (grant_q.size() == 0) begin
          $error("unexpected result transaction: alloc_index %0d status %0d",
                 out_tdata[IDX_W-1:0], out_tuser);
          fail_total++;
        end else begin
          g = grant_q.pop_front();
          if (out_tdata[IDX_W-1:0] !== g.idx) begin
            $error("alloc_index: expected %0d, actual %0d", g.idx, out_tdata[IDX_W-1:0]);
            fail_total++;
          end
          if (out_tuser !== g.status) begin
            $error("status: expected %0d, actual %0d", g.status, out_tuser);
            fail_total++;
          end
        end
      end
    end
    mismatch_count <= fail_total;
    grants_pending <= grant_q.size();
  end

endmodule

// ===== tb/sv/tb_first_free_bitmap_allocator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// First-free bitmap allocator: testbench top
// Drives allocate and free requests through a short directed sequence and a
// series of random phases under different block counts, with random idling
// on both channels. The checker beside the block judges every result.
// ----------------------------------------------------------------------------
module tb_first_free_bitmap_allocator_top
  import ffb_pkg::*;
();

  localparam int STALL_LIMIT = 5000;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;
  logic [0:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [3:0]  cfg_data   = '0;
  logic        calm       = 1'b0;
  int          mismatch_count;
  int          grants_pending;
  int          stall_cycles;
  int          alloc_reach;

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  first_free_bitmap_allocator_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  ffb_allocation_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .grants_pending (grants_pending)
  );

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm || ($urandom_range(0, 99) >= 35);
    end
  end

  // Any accepted transaction on any channel counts as progress.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)
        || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_request(input logic func, input logic [IDX_W-1:0] idx);
    while (!calm && $urandom_range(0, 99) < 35) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid   <= 1'b1;
    in_tuser[0] <= func;
    in_tdata    <= {1'b0, idx};
    do @(posedge clk); while (!in_tready);
  endtask

  // The count published by the checker is registered, so it trails the bus.
  task automatic drain_grants();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (grants_pending != 0) @(posedge clk);
  endtask

  task automatic write_blocks(input logic [CFG_W-1:0] blocks);
    cfg_valid <= 1'b1;
    cfg_data  <= blocks;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Mostly allocations and frees close to the filled region, so that the
  // store fills up and frees hit set bits; the rest frees anywhere.
  task automatic run_phase(input logic [CFG_W-1:0] blocks, input int n_requests);
    int               roll;
    logic [IDX_W-1:0] idx;
    write_blocks(blocks);
    repeat (n_requests) begin
      roll = $urandom_range(0, 99);
      if (roll < 58) begin
        idx = IDX_W'($urandom);
        send_request(FUNC_ALLOC, idx);
        if (alloc_reach < INDEX_LIMIT - 16) alloc_reach++;
      end else if (roll < 90) begin
        idx = IDX_W'($urandom_range(0, alloc_reach + 8));
        send_request(FUNC_FREE, idx);
      end else begin
        idx = IDX_W'($urandom);
        send_request(FUNC_FREE, idx);
      end
    end
    drain_grants();
  endtask

  initial begin
    alloc_reach = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset block count: first fit, free, double free, refill of a hole.
    send_request(FUNC_ALLOC, 15'd0);
    send_request(FUNC_ALLOC, 15'h7FFF);
    send_request(FUNC_ALLOC, 15'd0);
    send_request(FUNC_FREE, 15'd1);
    send_request(FUNC_FREE, 15'd1);
    send_request(FUNC_ALLOC, 15'd0);
    send_request(FUNC_FREE, 15'h7FFF);
    send_request(FUNC_FREE, 15'd0);
    send_request(FUNC_ALLOC, 15'h5555);
    drain_grants();

    // No blocks managed: every allocate is full, every free an error.
    write_blocks(4'd0);
    send_request(FUNC_ALLOC, 15'h2AAA);
    send_request(FUNC_FREE, 15'd2);
    send_request(FUNC_FREE, 15'h7FFF);
    drain_grants();

    // Register above the maximum saturates; the store has been kept.
    write_blocks(4'd15);
    send_request(FUNC_ALLOC, 15'd0);
    send_request(FUNC_FREE, 15'd3);
    send_request(FUNC_FREE, 15'h3FFF);
    send_request(FUNC_FREE, 15'h4000);
    drain_grants();

    // One block: just past its end is out of range.
    write_blocks(4'd1);
    send_request(FUNC_FREE, 15'd4096);
    send_request(FUNC_FREE, 15'd4095);
    send_request(FUNC_ALLOC, 15'd0);
    send_request(FUNC_FREE, 15'd2);
    drain_grants();

    alloc_reach = 8;
    run_phase(4'd8, 300);
    run_phase(4'd1, 260);
    calm <= 1'b1;
    run_phase(4'd15, 300);
    calm <= 1'b0;
    run_phase(4'd0, 40);
    run_phase(4'd3, 200);
    run_phase(4'd2, 150);
    run_phase(4'd8, 200);

    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && grants_pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== first_free_bitmap_allocator_top.f =====
sv/ffb_pkg.sv
sv/ffb_ram.sv
sv/ffb_scan.sv
sv/first_free_bitmap_allocator_top.sv
sv/ffb_chk.sv
tb/sv/ffb_allocation_checker.sv
tb/sv/tb_first_free_bitmap_allocator_top.sv
